// File: hw/rtl/aot_pkg.sv
// ----------------------------------------------------------------------------
// aot_pkg
// Types and constants shared by the aging object table.
// ----------------------------------------------------------------------------
package aot_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  localparam logic REQ_REPORT = 1'b0;
  localparam logic REQ_SNAP   = 1'b1;

  // Stored entry: key, data and stamp.
  localparam int unsigned ENTRY_W = 32 + 2 + 32 + 32 + 32 + 32 + 32;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_ms;
    logic signed [31:0] obj_id;
    logic [1:0]  obj_class;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic [31:0] obj_speed;
    logic [31:0] lane_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  report_status;
    logic signed [31:0] out_id;
    logic [1:0]  out_class;
    logic signed [31:0] out_lat;
    logic signed [31:0] out_lng;
    logic [31:0] out_speed;
    logic [31:0] out_lane;
    logic [5:0]  live_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  cls;
    logic [31:0] lat;
    logic [31:0] lng;
    logic [31:0] speed;
    logic [31:0] lane;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGE,
    S_SNAP,
    S_EMPTY,
    S_ACK
  } state_t;

endpackage

// File: hw/rtl/aot_ram.sv
// ----------------------------------------------------------------------------
// aot_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module aot_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/aging_object_table.sv
// ----------------------------------------------------------------------------
// aging_object_table
// Table of tracked objects with aging, in-order compaction and upsert.
// ----------------------------------------------------------------------------
// A request first ages the table, visiting each live entry through the one
// read port of the entry memory; a report then answers with an ack, and a
// snapshot emits its entries one per cycle. Busy stays high until the last
// result, so one request at a time.
// Reset clears the entry count and sets timeout_ms to 500; no clearing pass.
module aging_object_table #(
  parameter int unsigned DEPTH = aot_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  aot_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output aot_pkg::out_item_t out_item,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import aot_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Configuration register
  logic [15:0] timeout_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      timeout_r <= cfg_pwdata[15:0];
    end
  end

  // State
  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_r, rd_nxt;      // read index
  logic [CW-1:0] wr_r, wr_nxt;      // compaction write index
  logic          phase_r, phase_nxt; // 0 issue read, 1 data back
  logic          found_r, found_nxt;
  logic [AW-1:0] slot_r, slot_nxt;

  // Memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  aot_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  logic [31:0] age;
  logic        keep;
  assign age  = req_r.now_ms - rdata.stamp;
  assign keep = age < {16'd0, timeout_r};

  entry_t new_e;
  assign new_e = '{key: req_r.obj_id, cls: req_r.obj_class, lat: req_r.latitude,
                   lng: req_r.longitude, speed: req_r.obj_speed,
                   lane: req_r.lane_number, stamp: req_r.now_ms};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_AGE;
      S_AGE: begin
        if (rd_r == count_r && !phase_r) begin
          if (req_r.req_type == REQ_SNAP) begin
            state_nxt = (wr_r == '0) ? S_EMPTY : S_SNAP;
          end else begin
            state_nxt = S_ACK;
          end
        end
      end
      S_SNAP: if (phase_r && rd_r == count_r) state_nxt = S_IDLE;
      S_EMPTY: state_nxt = S_IDLE;
      S_ACK: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    count_nxt = count_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    phase_nxt = phase_r;
    found_nxt = found_r;
    slot_nxt  = slot_r;
    we        = 1'b0;
    waddr     = wr_r[AW-1:0];
    wdata     = rdata;
    raddr     = rd_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_nxt = '0; wr_nxt = '0; phase_nxt = 1'b0; found_nxt = 1'b0;
      end
      S_AGE: begin
        if (!phase_r) begin
          if (rd_r == count_r) begin
            // Aging done: commit count, set up snapshot or upsert
            count_nxt = wr_r;
            rd_nxt    = '0;
            if (req_r.req_type == REQ_REPORT) begin
              if (found_r) begin
                we = 1'b1; waddr = slot_r; wdata = new_e;
              end else if (wr_r < CW'(DEPTH)) begin
                we = 1'b1; waddr = wr_r[AW-1:0]; wdata = new_e;
                count_nxt = wr_r + 1'b1;
              end
            end
          end else begin
            phase_nxt = 1'b1;
          end
        end else begin
          // Compact a survivor and look for the key
          phase_nxt = 1'b0;
          rd_nxt    = rd_r + 1'b1;
          if (keep) begin
            we     = 1'b1;
            wr_nxt = wr_r + 1'b1;
            if (!found_r && rdata.key == req_r.obj_id) begin
              found_nxt = 1'b1;
              slot_nxt  = wr_r[AW-1:0];
            end
          end
        end
      end
      S_SNAP: begin
        // Read pipeline: phase marks data valid for rd_r-1
        if (!phase_r) begin
          phase_nxt = 1'b1;
          rd_nxt = rd_r + 1'b1;
        end else if (rd_r != count_r) begin
          rd_nxt = rd_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rd_r    <= '0;
      wr_r    <= '0;
      phase_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      phase_r <= phase_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (state_r == S_IDLE && start) begin
      req_r <= in_item;
    end
  end

  // Ack status registered at the end of aging
  logic [1:0] status_r;
  always_ff @(posedge clk) begin
    if (state_r == S_AGE && !phase_r && rd_r == count_r) begin
      status_r <= found_r ? ST_UPDATED :
                  (wr_r < CW'(DEPTH)) ? ST_INSERTED : ST_DROPPED;
    end
  end

  // Outputs
  assign busy = (state_r != S_IDLE);

  always_comb begin
    out_strobe = 1'b0;
    out_item   = '0;
    unique case (state_r)
      S_ACK: begin
        out_strobe = 1'b1;
        out_item.result_kind   = KIND_ACK;
        out_item.report_status = status_r;
        out_item.out_id    = req_r.obj_id;
        out_item.out_class = req_r.obj_class;
        out_item.out_lat   = req_r.latitude;
        out_item.out_lng   = req_r.longitude;
        out_item.out_speed = req_r.obj_speed;
        out_item.out_lane  = req_r.lane_number;
        out_item.live_count = 6'(count_r);
        out_item.last      = 1'b1;
      end
      S_EMPTY: begin
        out_strobe = 1'b1;
        out_item.result_kind = KIND_EMPTY;
        out_item.last = 1'b1;
      end
      S_SNAP: begin
        out_strobe = phase_r;
        out_item.result_kind = KIND_ENTRY;
        out_item.out_id    = rdata.key;
        out_item.out_class = rdata.cls;
        out_item.out_lat   = rdata.lat;
        out_item.out_lng   = rdata.lng;
        out_item.out_speed = rdata.speed;
        out_item.out_lane  = rdata.lane;
        out_item.live_count = 6'(count_r);
        out_item.last      = (rd_r == count_r);
      end
      default: ;
    endcase
  end

endmodule

// File: dv/aging_object_table_checker.sv
// ----------------------------------------------------------------------------
// aging_object_table_checker
// Watches the request, result and register ports of the aging object table,
// predicts every result from its own copy of the table and compares each
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module aging_object_table_checker
  import aot_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_strobe,
  input  out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          result_count,
  output int          drop_count,
  output int          n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ADDR_TIMEOUT = 2'd0;

  entry_t      table_q [DEPTH];
  int unsigned live_n;
  logic [15:0] timeout_ms;
  out_item_t   expected_q [$];

  assign n_pending = expected_q.size();

  // Drop aged entries and close the gaps, keeping order.
  function automatic void age_out(logic [31:0] now);
    int unsigned w;
    w = 0;
    for (int unsigned r = 0; r < live_n; r++) begin
      if (32'(now - table_q[r].stamp) < {16'd0, timeout_ms}) begin
        table_q[w] = table_q[r];
        w++;
      end
    end
    live_n = w;
  endfunction

  function automatic out_item_t pack_result(logic [1:0] kind, logic [1:0] status,
                                            entry_t e, logic is_last);
    out_item_t o;
    o.result_kind   = kind;
    o.report_status = status;
    o.out_id        = e.key;
    o.out_class     = e.cls;
    o.out_lat       = e.lat;
    o.out_lng       = e.lng;
    o.out_speed     = e.speed;
    o.out_lane      = e.lane;
    o.live_count    = 6'(live_n);
    o.last          = is_last;
    return o;
  endfunction

  // Apply one request to the table and queue the results it should give.
  task automatic predict_request(in_item_t it);
    entry_t      e;
    logic [1:0]  status;
    int unsigned slot;
    bit          found;
    age_out(it.now_ms);
    if (it.req_type == REQ_SNAP) begin
      if (live_n == 0) begin
        e = '0;
        expected_q.push_back(pack_result(KIND_EMPTY, ST_UPDATED, e, 1'b1));
      end else begin
        for (int unsigned i = 0; i < live_n; i++)
          expected_q.push_back(pack_result(KIND_ENTRY, ST_UPDATED, table_q[i],
                                           i + 1 == live_n));
      end
    end else begin
      e.key   = it.obj_id;
      e.cls   = it.obj_class;
      e.lat   = it.latitude;
      e.lng   = it.longitude;
      e.speed = it.obj_speed;
      e.lane  = it.lane_number;
      e.stamp = it.now_ms;
      found = 0;
      slot  = 0;
      for (int unsigned i = 0; i < live_n; i++) begin
        if (!found && table_q[i].key == it.obj_id) begin
          found = 1;
          slot  = i;
        end
      end
      if (found) begin
        status = ST_UPDATED;
      end else if (live_n < DEPTH) begin
        status = ST_INSERTED;
        slot   = live_n;
        live_n++;
      end else begin
        status = ST_DROPPED;
        drop_count++;
      end
      if (status != ST_DROPPED) table_q[slot] = e;
      expected_q.push_back(pack_result(KIND_ACK, status, e, 1'b1));
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp, act);
      fail_count++;
    end
  endtask

  // Track transfers on all three ports at the rising edge.
  always @(posedge clk) begin
    out_item_t exp;
    if (!rst_n) begin
      live_n     = 0;
      timeout_ms = TIMEOUT_RST;
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_TIMEOUT)
        timeout_ms = cfg_pwdata[15:0];
      if (out_strobe) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_item);
          fail_count++;
        end else begin
          exp = expected_q.pop_front();
          check_field("result_kind", exp.result_kind, out_item.result_kind);
          check_field("report_status", exp.report_status, out_item.report_status);
          check_field("out_id", exp.out_id, out_item.out_id);
          check_field("out_class", exp.out_class, out_item.out_class);
          check_field("out_lat", exp.out_lat, out_item.out_lat);
          check_field("out_lng", exp.out_lng, out_item.out_lng);
          check_field("out_speed", exp.out_speed, out_item.out_speed);
          check_field("out_lane", exp.out_lane, out_item.out_lane);
          check_field("live_count", exp.live_count, out_item.live_count);
          check_field("last", exp.last, out_item.last);
        end
      end
      if (start && !busy) predict_request(in_item);
    end
  end

  initial begin
    fail_count   = 0;
    result_count = 0;
    drop_count   = 0;
  end

endmodule

// File: dv/aging_object_table_tb.sv
// ----------------------------------------------------------------------------
// aging_object_table_tb
// Drives reports and snapshots into the aging object table under several
// timeout settings, with bursty request timing and a wrapping clock, and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module aging_object_table_tb;
  import aot_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ADDR_TIMEOUT = 2'd0;
  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int          fail_count, result_count, drop_count, n_pending;
  int          request_count = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  logic [31:0] now_ms = 32'hFFFF_F000;
  logic [31:0] id_pool [40];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  aging_object_table dut (.*);

  aging_object_table_checker checker_i (.*);

  // Count cycles with no transfer anywhere; give up when the count runs out.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_psel && cfg_penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold start high until the block takes the item; idle between bursts.
  task automatic send(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    request_count++;
  endtask

  function automatic in_item_t report(logic [31:0] id);
    in_item_t it;
    it.req_type    = REQ_REPORT;
    it.now_ms      = now_ms;
    it.obj_id      = id;
    it.obj_class   = 2'($urandom_range(0, 3));
    it.latitude    = $urandom;
    it.longitude   = $urandom;
    it.obj_speed   = $urandom;
    it.lane_number = $urandom;
    return it;
  endfunction

  function automatic in_item_t snapshot();
    in_item_t it;
    it          = report($urandom);
    it.req_type = REQ_SNAP;
    return it;
  endfunction

  // Wait until every result is in, then write the timeout register.
  task automatic set_timeout(logic [15:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= ADDR_TIMEOUT;
    cfg_pwdata <= {16'($urandom_range(0, 65535)), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int       timeout;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (id_pool[i]) id_pool[i] = $urandom;

    // Directed: empty table, field extremes, update, aging at the boundary.
    send(snapshot());
    it = report(32'h8000_0000);
    it.obj_class = 2'd0; it.latitude = 32'h8000_0000; it.longitude = 32'h7FFF_FFFF;
    it.obj_speed = 32'h0; it.lane_number = 32'hFFFF_FFFF;
    send(it);
    it = report(32'h7FFF_FFFF);
    it.obj_class = 2'd3; it.latitude = 32'h7FFF_FFFF; it.longitude = 32'h8000_0000;
    it.obj_speed = 32'hFFFF_FFFF; it.lane_number = 32'h0;
    send(it);
    now_ms += 100;
    send(report(32'h8000_0000));
    send(snapshot());
    now_ms += 499;
    send(snapshot());
    now_ms += 1;
    send(snapshot());
    now_ms += 100;
    send(snapshot());

    // Directed: fill the table past its depth, then take a full snapshot.
    set_timeout(16'hFFFF);
    for (int i = 0; i < 33; i++) begin
      now_ms += 1;
      send(report(id_pool[i]));
    end
    send(snapshot());
    send(report(id_pool[5]));

    // Directed: a zero timeout removes everything on each request.
    set_timeout(16'd0);
    send(report(id_pool[0]));
    send(snapshot());

    // Random phases across timeout settings; keys mostly from a shared pool.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: timeout = 1;
        1: timeout = 500;
        2: timeout = 65535;
        3: timeout = $urandom_range(2, 4000);
        default: timeout = TIMEOUT_RST;
      endcase
      set_timeout(16'(timeout));
      for (int n = 0; n < 53; n++) begin
        case ($urandom_range(0, 19))
          0: now_ms = $urandom;
          1, 2: now_ms += timeout;
          default: now_ms += $urandom_range(0, timeout / 6);
        endcase
        if ($urandom_range(0, 4) == 0) send(snapshot());
        else if ($urandom_range(0, 9) == 0) send(report($urandom));
        else send(report(id_pool[$urandom_range(0, 39)]));
      end
    end

    // Drain: wait for every result, then let the block settle.
    @(negedge clk);
    start <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("Covered %0d requests and %0d results (%0d reports dropped on a full table)",
             request_count, result_count, drop_count);
    $display("Timeouts exercised: 500, 65535, 0, 1 and a random value, with clock wrap");
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
